// ----- rtl/ffba_pkg.sv -----
// Package for the first-fit block allocator: sizes, status codes, op codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package ffba_pkg;
	localparam int unsigned POOL_BYTES      = 1048576;
	localparam int unsigned HEADER_BYTES    = 12;
	localparam int unsigned MIN_SPLIT_BYTES = 4;
	localparam int unsigned MAX_BLOCKS      = 64;

	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned SZ_W  = $clog2(POOL_BYTES + 1);
	localparam int unsigned FLD_W = 20;
	localparam int unsigned STAT_W = 21;

	localparam logic [2:0] ST_DONE   = 3'd0;
	localparam logic [2:0] ST_ZERO   = 3'd1;
	localparam logic [2:0] ST_NOFIT  = 3'd2;
	localparam logic [2:0] ST_BADREL = 3'd3;
	localparam logic [2:0] ST_NULL   = 3'd4;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic              op;
		logic [FLD_W-1:0]  request_bytes;
		logic [FLD_W-1:0]  release_offset;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [FLD_W-1:0]  payload_offset;
		logic [STAT_W-1:0] used_bytes;
		logic [STAT_W-1:0] free_bytes;
		logic [STAT_W-1:0] largest_free;
		logic [6:0]        fragmentation_pct;
	} rsp_t;

	// divider handshake between sequencer and divide unit
	typedef struct packed {
		logic            start;
		logic [SZ_W+6:0] dividend;
		logic [SZ_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [SZ_W+6:0] quotient;
	} div_rsp_t;
endpackage

// ----- rtl/ffba_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
interface ffba_req_if import ffba_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/ffba_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
module ffba_div import ffba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int unsigned DW = SZ_W + 7;
	localparam int unsigned BW = $clog2(DW + 1);

	logic [DW-1:0]   quo_q;
	logic [SZ_W:0]   rem_q;
	logic [SZ_W-1:0] dvs_q;
	logic [BW-1:0]   bits_q;
	logic            busy_q;
	logic            done_q;
	logic [SZ_W:0]   trial;
	logic [SZ_W+1:0] diff;

	always_comb begin
		trial = {rem_q[SZ_W-1:0], quo_q[DW-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bits_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bits_q <= BW'(DW);
			end else if (busy_q) begin
				bits_q <= bits_q - 1'b1;
				if (bits_q == BW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[SZ_W+1]) begin
				rem_q <= diff[SZ_W:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, quo_q};
endmodule

// ----- rtl/ffba_table.sv -----
// Block table memory: one write port, one registered read port.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
module ffba_table import ffba_pkg::*; (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IDX_W-1:0]      waddr,
	input  logic [SZ_W+SZ_W:0]    wdata,
	input  logic [IDX_W-1:0]      raddr,
	output logic [SZ_W+SZ_W:0]    rdata
);
	logic [SZ_W+SZ_W:0] mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: sequencer over the block table and divider.
// Depends on ffba_pkg, ffba_if, ffba_table, ffba_div.
//
// channel  | dir | payload
// req_ch   | in  | op, request_bytes, release_offset
// rsp_ch   | out | status, payload_offset, used/free/largest bytes, fragmentation_pct
//
// Steps for one request: accept; search the entries in order; a split shifts the
// entries above up by one and writes the new free block before marking, a plain
// allocate just marks; a release marks, then checks each adjacent pair for two
// free blocks and merges them, moving the entries above down by one; a statistics
// walk over all entries; a divide (skipped when nothing is free); load the output.
// All table traffic goes through one memory with one write port and one
// registered read port. Reset clears the sequencer and sets the block count to
// one; entry 0 is written in the first state after reset, during which no request
// is taken. The result is held in an output register until transferred; the next
// request waits for that.
`timescale 1ns / 1ps
module first_fit_block_allocator import ffba_pkg::*; (
	input logic clk,
	input logic arst_n,
	ffba_req_if.sink   req_ch,
	ffba_rsp_if.source rsp_ch
);
	localparam int unsigned EW = SZ_W + SZ_W + 1;   // entry: free, start, size

	localparam logic [4:0] S_INIT   = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_SRD    = 5'd2;   // search: issue read
	localparam logic [4:0] S_SCHK   = 5'd3;   // search: check entry
	localparam logic [4:0] S_MVRD   = 5'd4;   // shift up: read k-1
	localparam logic [4:0] S_MVWR   = 5'd5;   // shift up: write k
	localparam logic [4:0] S_SPLIT  = 5'd6;   // write new free block at i+1
	localparam logic [4:0] S_MARK   = 5'd7;   // write entry i
	localparam logic [4:0] S_CRD0   = 5'd8;   // coalesce: read i
	localparam logic [4:0] S_CRD1   = 5'd9;   // coalesce: read i+1
	localparam logic [4:0] S_CCHK   = 5'd10;
	localparam logic [4:0] S_DRD    = 5'd11;  // drop: read k+1
	localparam logic [4:0] S_DWR    = 5'd12;  // drop: write k
	localparam logic [4:0] S_TRD    = 5'd13;  // stats: read
	localparam logic [4:0] S_TACC   = 5'd14;
	localparam logic [4:0] S_DIV    = 5'd15;
	localparam logic [4:0] S_DWAIT  = 5'd16;
	localparam logic [4:0] S_OUT    = 5'd17;
	localparam logic [4:0] S_CWAIT  = 5'd18;  // coalesce: wait read of i+1

	logic [4:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  i_q;      // walk index
	logic [CNT_W-1:0]  k_q;      // move index
	logic              op_q;
	logic [SZ_W-1:0]   need_q;
	logic [FLD_W-1:0]  off_q;
	logic [2:0]        status_q;
	logic [FLD_W-1:0]  payload_q;
	logic [SZ_W-1:0]   cur_start_q;
	logic [SZ_W-1:0]   cur_size_q;
	logic              cur_free_q;
	logic [SZ_W-1:0]   used_q;
	logic [SZ_W-1:0]   freeb_q;
	logic [SZ_W-1:0]   largest_q;
	logic              split_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [EW-1:0]     wdata;
	logic [IDX_W-1:0]  raddr;
	logic [EW-1:0]     rdata;
	logic              r_free;
	logic [SZ_W-1:0]   r_start;
	logic [SZ_W-1:0]   r_size;
	div_req_t          dreq;
	div_rsp_t          drsp;

	assign r_free  = rdata[EW-1];
	assign r_start = rdata[EW-2 -: SZ_W];
	assign r_size  = rdata[SZ_W-1:0];

	ffba_table u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	ffba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Split test: remainder must hold a header plus the minimum block, and the table must have a spare entry.
	logic [SZ_W+1:0] split_need;
	logic            fits;
	logic            can_split;
	assign split_need = {2'b00, need_q} + (SZ_W+2)'(HEADER_BYTES + MIN_SPLIT_BYTES);
	assign fits       = r_free && (r_size >= need_q);
	assign can_split  = ({2'b00, r_size} >= split_need) && (count_q < CNT_W'(MAX_BLOCKS));

	logic [SZ_W-1:0] hdr_c;
	assign hdr_c = SZ_W'(HEADER_BYTES);

	// Memory port mux.
	always_comb begin
		we    = 1'b0;
		waddr = i_q[IDX_W-1:0];
		wdata = '0;
		raddr = i_q[IDX_W-1:0];
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = {1'b1, SZ_W'(0), SZ_W'(POOL_BYTES - HEADER_BYTES)};
			end
			S_MVRD:  raddr = IDX_W'(k_q - 1'b1);
			S_MVWR: begin
				we    = 1'b1;
				waddr = k_q[IDX_W-1:0];
				wdata = rdata;
			end
			S_SPLIT: begin
				we    = 1'b1;
				waddr = IDX_W'(i_q + 1'b1);
				wdata = {1'b1, cur_start_q + hdr_c + need_q, cur_size_q - need_q - hdr_c};
			end
			S_MARK: begin
				we    = 1'b1;
				wdata = {~op_q ? 1'b0 : 1'b1, cur_start_q,
					(~op_q && split_q) ? need_q : cur_size_q};
			end
			S_CRD1:  raddr = IDX_W'(i_q + 1'b1);
			S_CWAIT: raddr = IDX_W'(i_q + 1'b1);
			S_CCHK: begin
				// merge i and i+1 when both free
				we    = cur_free_q && r_free;
				wdata = {1'b1, cur_start_q, cur_size_q + hdr_c + r_size};
				raddr = IDX_W'(i_q + 1'b1);
			end
			S_DRD:   raddr = IDX_W'(k_q + 1'b1);
			S_DWR: begin
				we    = 1'b1;
				waddr = k_q[IDX_W-1:0];
				wdata = rdata;
			end
			default: ;
		endcase
	end

	always_comb begin
		dreq.start    = (state_q == S_DIV) && (freeb_q != '0);
		dreq.dividend = (SZ_W+7)'(largest_q) * (SZ_W+7)'(100);
		dreq.divisor  = freeb_q;
	end

	assign req_ch.ready   = (state_q == S_IDLE) && !out_valid_q;
	assign rsp_ch.valid   = out_valid_q;
	assign rsp_ch.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			count_q     <= CNT_W'(1);
			out_valid_q <= 1'b0;
			i_q         <= '0;
			k_q         <= '0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (req_ch.valid && req_ch.ready) begin
						i_q <= '0;
						if (req_ch.payload.op == OP_ALLOC) begin
							state_q <= (req_ch.payload.request_bytes == '0) ? S_TRD : S_SRD;
						end else begin
							state_q <= (req_ch.payload.release_offset == '0) ? S_TRD : S_SRD;
						end
					end
				end
				S_SRD: begin
					if (i_q == count_q) begin
						i_q     <= '0;
						state_q <= S_TRD;
					end else begin
						state_q <= S_SCHK;
					end
				end
				S_SCHK: begin
					if (op_q == OP_ALLOC) begin
						if (fits) begin
							if (can_split) begin
								k_q     <= count_q;
								state_q <= (count_q > i_q + 1'b1) ? S_MVRD : S_SPLIT;
							end else begin
								state_q <= S_MARK;
							end
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_SRD;
						end
					end else begin
						if ({1'b0, r_start} + SZ_W'(HEADER_BYTES) ==
							(SZ_W+1)'(off_q)) begin
							state_q <= S_MARK;
							if (r_free) begin
								i_q     <= '0;
								state_q <= S_TRD;
							end
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_SRD;
						end
					end
				end
				S_MVRD: state_q <= S_MVWR;
				S_MVWR: begin
					k_q     <= k_q - 1'b1;
					state_q <= (k_q - 1'b1 > i_q + 1'b1) ? S_MVRD : S_SPLIT;
				end
				S_SPLIT: begin
					count_q <= count_q + 1'b1;
					state_q <= S_MARK;
				end
				S_MARK: begin
					if (op_q == OP_ALLOC) begin
						i_q     <= '0;
						state_q <= S_TRD;
					end else begin
						i_q     <= '0;
						state_q <= S_CRD0;
					end
				end
				S_CRD0: begin
					if (i_q + 1'b1 >= count_q) begin
						i_q     <= '0;
						state_q <= S_TRD;
					end else begin
						state_q <= S_CRD1;
					end
				end
				S_CRD1: state_q <= S_CWAIT;
				S_CWAIT: state_q <= S_CCHK;
				S_CCHK: begin
					if (cur_free_q && r_free) begin
						k_q     <= i_q + 1'b1;
						state_q <= (i_q + 2'd2 < count_q) ? S_DRD : S_DWR;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_CRD0;
					end
				end
				S_DRD: state_q <= S_DWR;
				S_DWR: begin
					if (k_q + 2'd2 < count_q) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_DRD;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_CRD0;
					end
				end
				S_TRD: state_q <= (i_q == count_q) ? S_DIV : S_TACC;
				S_TACC: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_TRD;
				end
				S_DIV: state_q <= (freeb_q == '0) ? S_OUT : S_DWAIT;
				S_DWAIT: if (drsp.done) state_q <= S_OUT;
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q      <= req_ch.payload.op;
				need_q    <= SZ_W'({req_ch.payload.request_bytes + 20'd3} & ~FLD_W'(3))
					| (SZ_W'(req_ch.payload.request_bytes > 20'hFFFFC) << FLD_W);
				off_q     <= req_ch.payload.release_offset;
				payload_q <= '0;
				used_q    <= '0;
				freeb_q   <= '0;
				largest_q <= '0;
				split_q   <= 1'b0;
				if (req_ch.payload.op == OP_ALLOC) begin
					status_q <= (req_ch.payload.request_bytes == '0) ? ST_ZERO : ST_NOFIT;
				end else begin
					status_q <= (req_ch.payload.release_offset == '0) ? ST_NULL : ST_BADREL;
				end
			end
			S_SCHK: begin
				cur_start_q <= r_start;
				cur_size_q  <= r_size;
				if (op_q == OP_ALLOC) begin
					if (fits) begin
						split_q   <= can_split;
						status_q  <= ST_DONE;
						payload_q <= FLD_W'(r_start + hdr_c);
					end
				end else if ({1'b0, r_start} + SZ_W'(HEADER_BYTES) == (SZ_W+1)'(off_q)
					&& !r_free) begin
					status_q <= ST_DONE;
				end
			end
			S_CRD1: begin
				// entry i arrives here; entry i+1 follows in the compare cycle
				cur_free_q  <= r_free;
				cur_start_q <= r_start;
				cur_size_q  <= r_size;
			end
			S_CCHK: begin
				if (cur_free_q && r_free) begin
					cur_size_q <= cur_size_q + hdr_c + r_size;
				end
			end
			S_TACC: begin
				if (r_free) begin
					freeb_q <= freeb_q + r_size;
					if (r_size > largest_q) largest_q <= r_size;
				end else begin
					used_q <= used_q + r_size;
				end
			end
			S_OUT: begin
				out_q.status            <= status_q;
				out_q.payload_offset    <= payload_q;
				out_q.used_bytes        <= STAT_W'(used_q);
				out_q.free_bytes        <= STAT_W'(freeb_q);
				out_q.largest_free      <= STAT_W'(largest_q);
				out_q.fragmentation_pct <= (freeb_q == '0) ? 7'd0 :
					7'(7'd100 - drsp.quotient[6:0]);
			end
			default: ;
		endcase
	end
endmodule

// ----- tb/first_fit_block_allocator_tb.sv -----
// Self-checking testbench for first_fit_block_allocator: directed table, then random traffic.
// Depends on ffba_pkg, ffba_if and the allocator RTL; checks every result against a typed row or the predictor.
`timescale 1ns / 1ps
module first_fit_block_allocator_tb;
	import ffba_pkg::*;

	logic clk;
	logic arst_n;

	ffba_req_if req_ch ();
	ffba_rsp_if rsp_ch ();

	first_fit_block_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch.sink),
		.rsp_ch (rsp_ch.source)
	);

	// Predicted block table, kept in address order like the block's own table.
	int unsigned pool_size [MAX_BLOCKS];
	int unsigned pool_start[MAX_BLOCKS];
	bit          pool_free [MAX_BLOCKS];
	int unsigned pool_count;

	// Payload offsets handed out and not yet released, used to aim releases.
	int unsigned live_offsets[$];

	rsp_t pending_rsp[$];
	int   error_count;

	// Idle percentages; changed by the stimulus process between phases.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          recv_hold;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("first_fit_block_allocator verification failed");
		$finish;
	end

	function automatic void pool_reset();
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			pool_size[k]  = 0;
			pool_start[k] = 0;
			pool_free[k]  = 1'b0;
		end
		pool_size[0] = POOL_BYTES - HEADER_BYTES;
		pool_free[0] = 1'b1;
		pool_count   = 1;
		live_offsets.delete();
	endfunction

	// Merge every run of adjacent free blocks into one, shifting the table down.
	function automatic void pool_merge();
		int unsigned i;
		i = 0;
		while (i + 1 < pool_count) begin
			if (pool_free[i] && pool_free[i+1]) begin
				pool_size[i] = pool_size[i] + HEADER_BYTES + pool_size[i+1];
				for (int unsigned k = i + 1; k + 1 < pool_count; k++) begin
					pool_size[k]  = pool_size[k+1];
					pool_start[k] = pool_start[k+1];
					pool_free[k]  = pool_free[k+1];
				end
				pool_count--;
				pool_size[pool_count]  = 0;
				pool_start[pool_count] = 0;
				pool_free[pool_count]  = 1'b0;
			end else begin
				i++;
			end
		end
	endfunction

	// Apply one request to the predicted table and return the expected result.
	function automatic rsp_t pool_apply(req_t rq);
		rsp_t        r;
		int unsigned need;
		longint unsigned used, freeb, largest;
		bit          found;
		r = '0;
		used = 0; freeb = 0; largest = 0;
		if (rq.op == OP_ALLOC) begin
			if (rq.request_bytes == 0) begin
				r.status = ST_ZERO;
			end else begin
				need  = (int'(rq.request_bytes) + 3) & ~3;
				found = 1'b0;
				for (int unsigned i = 0; i < pool_count && !found; i++) begin
					if (pool_free[i] && pool_size[i] >= need) begin
						found = 1'b1;
						// Split only when the tail can hold a header plus the minimum block
						// and the table has a spare entry; otherwise hand out the whole block.
						if (pool_size[i] >= need + HEADER_BYTES + MIN_SPLIT_BYTES
								&& pool_count < MAX_BLOCKS) begin
							for (int unsigned k = pool_count; k > i + 1; k--) begin
								pool_size[k]  = pool_size[k-1];
								pool_start[k] = pool_start[k-1];
								pool_free[k]  = pool_free[k-1];
							end
							pool_count++;
							pool_start[i+1] = pool_start[i] + HEADER_BYTES + need;
							pool_size[i+1]  = pool_size[i] - need - HEADER_BYTES;
							pool_free[i+1]  = 1'b1;
							pool_size[i]    = need;
						end
						pool_free[i]     = 1'b0;
						r.payload_offset = FLD_W'(pool_start[i] + HEADER_BYTES);
						r.status         = ST_DONE;
						live_offsets.push_back(pool_start[i] + HEADER_BYTES);
					end
				end
				if (!found) r.status = ST_NOFIT;
			end
		end else if (rq.release_offset == 0) begin
			r.status = ST_NULL;
		end else begin
			r.status = ST_BADREL;
			for (int unsigned i = 0; i < pool_count; i++) begin
				if (pool_start[i] + HEADER_BYTES == rq.release_offset && r.status == ST_BADREL
						&& !pool_free[i]) begin
					pool_free[i] = 1'b1;
					r.status     = ST_DONE;
					foreach (live_offsets[j])
						if (live_offsets[j] == rq.release_offset) begin
							live_offsets.delete(j);
							break;
						end
					pool_merge();
					break;
				end else if (pool_start[i] + HEADER_BYTES == rq.release_offset) begin
					break;
				end
			end
		end
		for (int unsigned i = 0; i < pool_count; i++) begin
			if (pool_free[i]) begin
				freeb += pool_size[i];
				if (pool_size[i] > largest) largest = pool_size[i];
			end else begin
				used += pool_size[i];
			end
		end
		r.used_bytes   = used[STAT_W-1:0];
		r.free_bytes   = freeb[STAT_W-1:0];
		r.largest_free = largest[STAT_W-1:0];
		if (freeb > 0) r.fragmentation_pct = 7'(100 - (largest * 100) / freeb);
		return r;
	endfunction

	// Offer one request, wait for its transfer, then log the expected result.
	// Valid stays high after the transfer unless the next call idles or the
	// sender drains.
	task automatic send_req(req_t rq, bit use_typed, rsp_t typed);
		rsp_t predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
			while (($urandom_range(99) < send_idle_pct)) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= rq;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = pool_apply(rq);
		if (use_typed && predicted !== typed)
			$display("%0t directed row disagrees with predictor: typed %p predicted %p",
				$time, typed, predicted);
		pending_rsp.push_back(use_typed ? typed : predicted);
	endtask

	function automatic req_t make_alloc(int unsigned bytes);
		req_t rq;
		rq = '0;
		rq.op = OP_ALLOC;
		rq.request_bytes = bytes[FLD_W-1:0];
		rq.release_offset = FLD_W'($urandom());
		return rq;
	endfunction

	function automatic req_t make_release(int unsigned off);
		req_t rq;
		rq = '0;
		rq.op = OP_RELEASE;
		rq.request_bytes = FLD_W'($urandom());
		rq.release_offset = off[FLD_W-1:0];
		return rq;
	endfunction

	function automatic rsp_t make_rsp(logic [2:0] st, int unsigned pay, int unsigned used,
			int unsigned freeb, int unsigned largest, int unsigned frag);
		rsp_t r;
		r.status = st;
		r.payload_offset = pay[FLD_W-1:0];
		r.used_bytes = used[STAT_W-1:0];
		r.free_bytes = freeb[STAT_W-1:0];
		r.largest_free = largest[STAT_W-1:0];
		r.fragmentation_pct = frag[6:0];
		return r;
	endfunction

	// Random request: mostly allocations of small sizes and releases of live blocks,
	// with some large and zero sizes, null releases and bad offsets mixed in.
	function automatic req_t random_req();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			if ($urandom_range(19) == 0) return make_alloc($urandom());
			if ($urandom_range(9) == 0) return make_alloc($urandom_range(65536, 1));
			return make_alloc($urandom_range(4096, 1));
		end
		if (pick < 85 && live_offsets.size() > 0)
			return make_release(live_offsets[$urandom_range(live_offsets.size() - 1)]);
		if (pick < 90) return make_release(0);
		if (pick < 94) return make_alloc(0);
		return make_release($urandom());
	endfunction

	task automatic drain_wait();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	typedef struct {
		req_t rq;
		bit   typed;
		rsp_t expected;
	} stim_row_t;

	// Receiver: stall at random, with one long hold-off while requests keep coming.
	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (recv_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (3000) @(posedge clk);
				recv_hold = 1'b0;
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each transferred result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %p", $time, rsp_ch.payload);
				error_count++;
			end else begin
				rsp_t exp_rsp;
				exp_rsp = pending_rsp.pop_front();
				if (rsp_ch.payload.status !== exp_rsp.status) begin
					$display("%0t status: expected %0d actual %0d", $time,
						exp_rsp.status, rsp_ch.payload.status);
					error_count++;
				end
				if (rsp_ch.payload.payload_offset !== exp_rsp.payload_offset) begin
					$display("%0t payload_offset: expected %0d actual %0d", $time,
						exp_rsp.payload_offset, rsp_ch.payload.payload_offset);
					error_count++;
				end
				if (rsp_ch.payload.used_bytes !== exp_rsp.used_bytes) begin
					$display("%0t used_bytes: expected %0d actual %0d", $time,
						exp_rsp.used_bytes, rsp_ch.payload.used_bytes);
					error_count++;
				end
				if (rsp_ch.payload.free_bytes !== exp_rsp.free_bytes) begin
					$display("%0t free_bytes: expected %0d actual %0d", $time,
						exp_rsp.free_bytes, rsp_ch.payload.free_bytes);
					error_count++;
				end
				if (rsp_ch.payload.largest_free !== exp_rsp.largest_free) begin
					$display("%0t largest_free: expected %0d actual %0d", $time,
						exp_rsp.largest_free, rsp_ch.payload.largest_free);
					error_count++;
				end
				if (rsp_ch.payload.fragmentation_pct !== exp_rsp.fragmentation_pct) begin
					$display("%0t fragmentation_pct: expected %0d actual %0d", $time,
						exp_rsp.fragmentation_pct, rsp_ch.payload.fragmentation_pct);
					error_count++;
				end
			end
		end
	end

	// Stimulus: reset, directed table, table fill, then random traffic in three idle phases.
	initial begin
		stim_row_t rows[$];
		int unsigned full;
		full = POOL_BYTES - HEADER_BYTES;
		error_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		arst_n = 1'b0;
		pool_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rows with typed results come straight from a fresh table.
		rows.push_back('{make_alloc(0), 1, make_rsp(ST_ZERO, 0, 0, full, full, 0)});
		rows.push_back('{make_release(0), 1, make_rsp(ST_NULL, 0, 0, full, full, 0)});
		rows.push_back('{make_release(12), 1, make_rsp(ST_BADREL, 0, 0, full, full, 0)});
		rows.push_back('{make_alloc(20'hFFFFF), 1, make_rsp(ST_NOFIT, 0, 0, full, full, 0)});
		rows.push_back('{make_release(20'hFFFFF), 1, make_rsp(ST_BADREL, 0, 0, full, full, 0)});
		rows.push_back('{make_alloc(1), 1, make_rsp(ST_DONE, 12, 4, full - 16, full - 16, 0)});
		rows.push_back('{make_release(12), 1, make_rsp(ST_DONE, 0, 0, full, full, 0)});
		// Exact fit of the whole pool, then a miss, then its release.
		rows.push_back('{make_alloc(full), 1, make_rsp(ST_DONE, 12, full, 0, 0, 0)});
		rows.push_back('{make_alloc(4), 1, make_rsp(ST_NOFIT, 0, full, 0, 0, 0)});
		rows.push_back('{make_release(12), 1, make_rsp(ST_DONE, 0, 0, full, full, 0)});
		// Tail too short to split, a double release, and fragmentation with holes.
		rows.push_back('{make_alloc(full - 12), 0, '0});
		rows.push_back('{make_release(12), 0, '0});
		rows.push_back('{make_release(12), 0, '0});
		rows.push_back('{make_alloc(3), 0, '0});
		rows.push_back('{make_alloc(100), 0, '0});
		rows.push_back('{make_alloc(7), 0, '0});
		rows.push_back('{make_release(12), 0, '0});
		rows.push_back('{make_release(144), 0, '0});
		rows.push_back('{make_alloc(2), 0, '0});
		rows.push_back('{make_release(28), 0, '0});
		rows.push_back('{make_release(12), 0, '0});
		foreach (rows[i]) send_req(rows[i].rq, rows[i].typed, rows[i].expected);

		// Fill the table past its last entry so allocations go out whole.
		for (int n = 0; n < 70; n++) send_req(make_alloc($urandom_range(64, 1)), 0, '0);
		send_req(make_alloc(4), 0, '0);
		while (live_offsets.size() > 0)
			send_req(make_release(live_offsets[$urandom_range(live_offsets.size() - 1)]), 0, '0);
		drain_wait();

		send_idle_pct = 26;
		recv_idle_pct = 64;
		recv_hold = 1'b1;
		for (int n = 0; n < 530; n++) send_req(random_req(), 0, '0);
		// Pause until every expected result is in before changing the idle mix.
		drain_wait();
		send_idle_pct = 64;
		recv_idle_pct = 26;
		for (int n = 0; n < 530; n++) send_req(random_req(), 0, '0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int n = 0; n < 530; n++) send_req(random_req(), 0, '0);

		drain_wait();
		if (error_count == 0)
			$display("first_fit_block_allocator verification clean");
		else
			$display("first_fit_block_allocator verification failed");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/ffba_pkg.sv
rtl/ffba_if.sv
rtl/ffba_div.sv
rtl/ffba_table.sv
rtl/first_fit_block_allocator.sv
tb/first_fit_block_allocator_tb.sv
